FILE: design/avs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avs_pkg
// Shared types and constants for the converter voltage statistics block.
// ----------------------------------------------------------------------------
package avs_pkg;

    // Input kind codes as they arrive on the stream
    localparam int KIND_BITS = 2;
    localparam logic [KIND_BITS-1:0] KIND_SAMPLE = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_START  = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_CLEAR  = 2'd2;

    // Operation codes after classification
    typedef logic [1:0] t_code;
    localparam t_code OP_SAMPLE = 2'd0;
    localparam t_code OP_START  = 2'd1;
    localparam t_code OP_CLEAR  = 2'd2;
    localparam t_code OP_NONE   = 2'd3;

    // Scaled result fields and full-scale register
    localparam int CV_BITS  = 10;
    localparam int FS_BITS  = 10;
    localparam int QUO_BITS = 10;
    localparam logic [FS_BITS-1:0] FS_RESET = 10'd500;

    // Configuration port
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic REG_FULL_SCALE = 1'b0;   // word index taken from paddr[2]

endpackage

FILE: design/avs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avs_front
// Accepts input items, classifies them into operations and holds them in a
// two-entry queue for the execution side.
// ----------------------------------------------------------------------------
module avs_front #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_valid,
    output logic                          o_s_ready,
    input  logic [avs_pkg::KIND_BITS-1:0] i_kind,
    input  logic [SAMPLE_BITS-1:0]        i_value,
    output logic                          o_q_valid,
    output avs_pkg::t_code                o_q_code,
    output logic [SAMPLE_BITS-1:0]        o_q_value,
    input  logic                          i_q_pop
);
    import avs_pkg::*;

    t_code                  r_code  [2];
    logic [SAMPLE_BITS-1:0] r_value [2];
    logic                   r_wr_ptr;
    logic                   r_rd_ptr;
    logic [1:0]             r_count;
    t_code                  n_code;
    logic                   w_push;
    logic                   w_pop;

    // classify the incoming kind
    always_comb begin
        unique case (i_kind)
            KIND_SAMPLE: n_code = OP_SAMPLE;
            KIND_START:  n_code = OP_START;
            KIND_CLEAR:  n_code = OP_CLEAR;
            default:     n_code = OP_NONE;
        endcase
    end

    assign o_s_ready = (r_count != 2'd2);
    assign w_push    = i_s_valid && o_s_ready;
    assign w_pop     = i_q_pop && o_q_valid;
    assign o_q_valid = (r_count != 2'd0);
    assign o_q_code  = r_code[r_rd_ptr];
    assign o_q_value = r_value[r_rd_ptr];

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) r_wr_ptr <= ~r_wr_ptr;
            if (w_pop)  r_rd_ptr <= ~r_rd_ptr;
            if (w_push && !w_pop)      r_count <= r_count + 2'd1;
            else if (w_pop && !w_push) r_count <= r_count - 2'd1;
        end
    end

    // queue entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_code[r_wr_ptr]  <= n_code;
            r_value[r_wr_ptr] <= i_value;
        end
    end

endmodule

FILE: design/avs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avs_back
// Executes queued operations on the statistics, scales the values, divides
// for the average and holds the result in the output register.
// ----------------------------------------------------------------------------
module avs_back #(
    parameter int SAMPLE_BITS = 10,
    parameter int COUNT_BITS  = 32,
    parameter int OUT_W       = 80
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [avs_pkg::FS_BITS-1:0]  i_full_scale,
    input  logic                         i_q_valid,
    input  avs_pkg::t_code               i_q_code,
    input  logic [SAMPLE_BITS-1:0]       i_q_value,
    output logic                         o_q_pop,
    output logic                         o_m_valid,
    input  logic                         i_m_ready,
    output logic [OUT_W-1:0]             o_m_data
);
    import avs_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int CB  = COUNT_BITS;
    localparam int W   = SB + CB;          // sum width
    localparam int H   = W / 2;            // low half of sum for partial products
    localparam int PW  = SB + FS_BITS;     // scaled product width
    localparam int NW  = CB + QUO_BITS;    // divider width
    localparam int STEP_BITS = $clog2(QUO_BITS);

    localparam int OFS_CUR = 0;
    localparam int OFS_MIN = CV_BITS;
    localparam int OFS_MAX = 2 * CV_BITS;
    localparam int OFS_AVG = 3 * CV_BITS;
    localparam int OFS_CNT = 4 * CV_BITS;
    localparam int OFS_RUN = 4 * CV_BITS + CB;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]              r_state;
    logic [SB-1:0]           r_latest;
    logic [SB-1:0]           r_min;
    logic [SB-1:0]           r_max;
    logic [CB-1:0]           r_count;
    logic [W-1:0]            r_sum;
    logic                    r_running;
    logic                    r_first;
    logic [H+FS_BITS-1:0]    r_lo;
    logic [W-H+FS_BITS-1:0]  r_hi;
    logic [CV_BITS-1:0]      r_cur_cv;
    logic [CV_BITS-1:0]      r_min_cv;
    logic [CV_BITS-1:0]      r_max_cv;
    logic [NW-1:0]           r_rem;
    logic [NW-1:0]           r_dsr;
    logic [QUO_BITS-1:0]     r_quo;
    logic [STEP_BITS-1:0]    r_step;
    logic                    r_m_valid;
    logic [OUT_W-1:0]        r_m_data;

    logic [PW-1:0]           w_cur_prod;
    logic [PW-1:0]           w_min_prod;
    logic [PW-1:0]           w_max_prod;
    logic [W+FS_BITS-1:0]    w_prod;
    logic                    w_ge;
    logic                    w_load;
    logic [CV_BITS-1:0]      w_avg;
    logic [OUT_W-1:0]        n_m_data;

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    // scaling multipliers for the latest, minimum and maximum values
    assign w_cur_prod = PW'(r_latest) * PW'(i_full_scale);
    assign w_min_prod = PW'(r_min) * PW'(i_full_scale);
    assign w_max_prod = PW'(r_max) * PW'(i_full_scale);

    // recombine the two partial products of sum * full scale
    assign w_prod = {r_hi, {H{1'b0}}} + (W + FS_BITS)'(r_lo);

    // restoring division step
    assign w_ge = (r_rem >= r_dsr);

    assign w_avg  = (r_count == '0) ? '0 : r_quo;
    assign w_load = (r_state == S_DONE) && (!r_m_valid || i_m_ready);

    // result packing, lowest field first
    always_comb begin
        n_m_data = '0;
        n_m_data[OFS_CUR +: CV_BITS] = r_cur_cv;
        n_m_data[OFS_MIN +: CV_BITS] = r_min_cv;
        n_m_data[OFS_MAX +: CV_BITS] = r_max_cv;
        n_m_data[OFS_AVG +: CV_BITS] = w_avg;
        n_m_data[OFS_CNT +: CB]      = r_count;
        n_m_data[OFS_RUN]            = r_running;
    end

    // sequencer and statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_latest  <= '0;
            r_min     <= '0;
            r_max     <= '0;
            r_count   <= '0;
            r_sum     <= '0;
            r_running <= 1'b0;
            r_first   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= S_MUL;
                        unique case (i_q_code)
                            OP_SAMPLE: begin
                                if (r_running) begin
                                    r_latest <= i_q_value;
                                    if (r_first) begin
                                        r_min   <= i_q_value;
                                        r_max   <= i_q_value;
                                        r_first <= 1'b0;
                                    end else begin
                                        if (i_q_value < r_min) r_min <= i_q_value;
                                        if (i_q_value > r_max) r_max <= i_q_value;
                                    end
                                    // count and sum hold once the count saturates
                                    if (!(&r_count)) begin
                                        r_count <= r_count + 1'b1;
                                        r_sum   <= r_sum + W'(i_q_value);
                                    end
                                end
                            end
                            OP_START: begin
                                r_running <= 1'b1;
                                r_first   <= 1'b1;
                            end
                            OP_CLEAR: begin
                                r_latest  <= '0;
                                r_min     <= '0;
                                r_max     <= '0;
                                r_count   <= '0;
                                r_sum     <= '0;
                                r_running <= 1'b0;
                                r_first   <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_MUL:  r_state <= S_ADD;
                S_ADD:  r_state <= S_DIV;
                S_DIV:  if (r_step == '0) r_state <= S_DONE;
                S_DONE: if (w_load) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // arithmetic datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_MUL: begin
                r_lo     <= (H + FS_BITS)'(r_sum[H-1:0]) * (H + FS_BITS)'(i_full_scale);
                r_hi     <= (W - H + FS_BITS)'(r_sum[W-1:H])
                            * (W - H + FS_BITS)'(i_full_scale);
                r_cur_cv <= w_cur_prod[PW-1:SB];
                r_min_cv <= w_min_prod[PW-1:SB];
                r_max_cv <= w_max_prod[PW-1:SB];
            end
            S_ADD: begin
                r_rem  <= w_prod[W+FS_BITS-1:SB];
                r_dsr  <= NW'(r_count) << (QUO_BITS - 1);
                r_quo  <= '0;
                r_step <= STEP_BITS'(QUO_BITS - 1);
            end
            S_DIV: begin
                if (w_ge) r_rem <= r_rem - r_dsr;
                r_quo  <= {r_quo[QUO_BITS-2:0], w_ge};
                r_dsr  <= r_dsr >> 1;
                r_step <= r_step - 1'b1;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) r_m_data <= n_m_data;
    end

    assign o_m_valid = r_m_valid;
    assign o_m_data  = r_m_data;

endmodule

FILE: design/adc_voltage_statistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_voltage_statistics
// Voltmeter statistics on converter samples: latest, minimum, maximum and
// average in hundredths of a volt, with sample count and running flag.
// ----------------------------------------------------------------------------
// An accepted item passes the back end's update, multiply, add, 10-step average
// divider and output-load states in order; output load waits for a free output
// register, and the back end takes no new item until that load is done.
// Input side takes up to two further items while the back end is busy.
// Reset (synchronous, active low) clears statistics, queue and output valid;
// full scale returns to 500.
module adc_voltage_statistics #(
    parameter int SAMPLE_BITS = 10,
    parameter int COUNT_BITS  = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // input stream
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]        s_axis_tdata,  // sample_value
    input  logic [avs_pkg::KIND_BITS-1:0]           s_axis_tuser,  // kind
    // result stream
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // current, min, max, avg centivolts (10 each), samples_taken, is_running
    output logic [((4*avs_pkg::CV_BITS+COUNT_BITS+1+7)/8)*8-1:0] m_axis_tdata,
    // configuration
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [avs_pkg::APB_ADDR_BITS-1:0]       paddr,
    input  logic [avs_pkg::APB_DATA_BITS-1:0]       pwdata,
    output logic [avs_pkg::APB_DATA_BITS-1:0]       prdata,
    output logic                                    pready
);
    import avs_pkg::*;

    localparam int OUT_W = ((4 * CV_BITS + COUNT_BITS + 1 + 7) / 8) * 8;

    logic [FS_BITS-1:0]     r_full_scale;
    logic                   w_q_valid;
    t_code                  w_q_code;
    logic [SAMPLE_BITS-1:0] w_q_value;
    logic                   w_q_pop;

    // configuration register
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_scale <= FS_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == REG_FULL_SCALE)) begin
            r_full_scale <= pwdata[FS_BITS-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_FULL_SCALE) ? APB_DATA_BITS'(r_full_scale) : '0;

    avs_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_kind    (s_axis_tuser),
        .i_value   (s_axis_tdata[SAMPLE_BITS-1:0]),
        .o_q_valid (w_q_valid),
        .o_q_code  (w_q_code),
        .o_q_value (w_q_value),
        .i_q_pop   (w_q_pop)
    );

    avs_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .OUT_W       (OUT_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_full_scale (r_full_scale),
        .i_q_valid    (w_q_valid),
        .i_q_code     (w_q_code),
        .i_q_value    (w_q_value),
        .o_q_pop      (w_q_pop),
        .o_m_valid    (m_axis_tvalid),
        .i_m_ready    (m_axis_tready),
        .o_m_data     (m_axis_tdata)
    );

endmodule

FILE: design/avs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avs_checker
// Port-level checks for the voltage statistics block, bound to the top level.
// ----------------------------------------------------------------------------
module avs_checker #(
    parameter int COUNT_BITS  = 32
) (
    input logic                                    i_clk,
    input logic                                    i_rst_n,
    input logic                                    m_axis_tvalid,
    input logic                                    m_axis_tready,
    input logic [((4*avs_pkg::CV_BITS+COUNT_BITS+1+7)/8)*8-1:0] m_axis_tdata,
    input logic                                    psel,
    input logic                                    penable,
    input logic                                    pwrite,
    input logic [avs_pkg::APB_ADDR_BITS-1:0]       paddr,
    input logic [avs_pkg::APB_DATA_BITS-1:0]       pwdata,
    input logic [avs_pkg::APB_DATA_BITS-1:0]       prdata,
    input logic                                    pready
);
    import avs_pkg::*;

    localparam int OFS_MIN = CV_BITS;
    localparam int OFS_MAX = 2 * CV_BITS;
    localparam int OFS_AVG = 3 * CV_BITS;
    localparam int OFS_CNT = 4 * CV_BITS;

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // no samples means zero average
    a_avg_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[OFS_CNT +: COUNT_BITS] == '0)
        |-> (m_axis_tdata[OFS_AVG +: CV_BITS] == '0))
        else $error("nonzero average with no samples");

    // minimum never above maximum
    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid
        |-> (m_axis_tdata[OFS_MIN +: CV_BITS] <= m_axis_tdata[OFS_MAX +: CV_BITS]))
        else $error("minimum above maximum");

    // full-scale write reads back
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && (paddr[2] == REG_FULL_SCALE)
        |=> (paddr[2] != REG_FULL_SCALE)
            || (prdata[FS_BITS-1:0] == $past(pwdata[FS_BITS-1:0])))
        else $error("full-scale readback mismatch");

endmodule

bind adc_voltage_statistics avs_checker #(
    .COUNT_BITS  (COUNT_BITS)
) u_avs_checker (.*);

FILE: test/tb_adc_voltage_statistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adc_voltage_statistics
// Streams converter samples, start and clear commands into the voltmeter
// statistics block and checks every returned reading against an in-bench
// predictor of latest, minimum, maximum and average voltage, sample count
// and running flag. Full scale is reprogrammed between traffic phases, and
// sender gaps, receiver stalls and one long receiver hold-off vary per phase.
// ----------------------------------------------------------------------------
module tb_adc_voltage_statistics;
    import avs_pkg::*;

    localparam int SAMPLE_W    = 10;
    localparam int COUNT_W     = 32;
    localparam int IN_DATA_W   = ((SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((4 * CV_BITS + COUNT_W + 1 + 7) / 8) * 8;
    localparam int DRAIN_SLACK = 40;     // extra wait after the queues drain
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 355;
    localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
    localparam logic [APB_ADDR_BITS-1:0] ADDR_FULL_SCALE = {REG_FULL_SCALE, 2'b00};

    typedef struct {
        logic [KIND_BITS-1:0] kind;
        logic [SAMPLE_W-1:0]  value;
    } adc_item_t;

    typedef struct {
        logic [CV_BITS-1:0] current_cv;
        logic [CV_BITS-1:0] min_cv;
        logic [CV_BITS-1:0] max_cv;
        logic [CV_BITS-1:0] avg_cv;
        logic [COUNT_W-1:0] count;
        logic               running;
    } reading_t;

    // DUT ports
    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_DATA_W-1:0]     s_axis_tdata = '0;  // sample_value
    logic [KIND_BITS-1:0]     s_axis_tuser = '0;  // kind
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    // current, min, max, avg centivolts, samples_taken, is_running
    logic [OUT_DATA_W-1:0]    m_axis_tdata;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    // Stimulus control
    adc_item_t items_to_send[$];
    reading_t  expected_readings[$];
    int        tx_idle_pct = 0;
    int        rx_stall_pct = 0;
    bit        hold_armed = 1'b0;
    bit        rx_hold = 1'b0;
    int        hold_count = 0;
    int        error_count = 0;

    // Predicted voltmeter state
    logic [FS_BITS-1:0]          fs_model = FS_RESET;
    logic [SAMPLE_W-1:0]         latest_raw = '0;
    logic [SAMPLE_W-1:0]         lowest_raw = '0;
    logic [SAMPLE_W-1:0]         highest_raw = '0;
    logic [COUNT_W-1:0]          taken = '0;
    logic [SAMPLE_W+COUNT_W-1:0] raw_sum = '0;
    bit                          running = 1'b0;
    bit                          seed_next = 1'b0;

    adc_voltage_statistics #(
        .SAMPLE_BITS(SAMPLE_W),
        .COUNT_BITS (COUNT_W)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(string what, longint got, longint want);
        error_count++;
        $display("%0t ns: %s mismatch: got %0d, want %0d", $realtime, what, got, want);
    endtask

    // Raw converter code to hundredths of a volt, truncated
    function automatic logic [CV_BITS-1:0] raw_to_cv(logic [SAMPLE_W-1:0] raw);
        logic [SAMPLE_W+FS_BITS-1:0] prod;
        prod = raw * fs_model;
        return prod[SAMPLE_W +: CV_BITS];
    endfunction

    function automatic logic [CV_BITS-1:0] mean_cv();
        logic [63:0] scaled;
        logic [63:0] quo;
        if (taken == '0)
            return '0;
        scaled = (64'(raw_sum) * 64'(fs_model)) >> SAMPLE_W;
        quo = scaled / 64'(taken);
        return quo[CV_BITS-1:0];
    endfunction

    // Apply one accepted item to the predicted state, queue the reading it gives
    task automatic predict_reading(logic [KIND_BITS-1:0] kind, logic [SAMPLE_W-1:0] v);
        reading_t r;
        case (kind)
            KIND_SAMPLE: begin
                if (running) begin
                    latest_raw = v;
                    if (seed_next) begin
                        lowest_raw = v;
                        highest_raw = v;
                        seed_next = 1'b0;
                    end else begin
                        if (v < lowest_raw) lowest_raw = v;
                        if (v > highest_raw) highest_raw = v;
                    end
                    // count and sum hold once the count saturates
                    if (taken != '1) begin
                        taken = taken + 1'b1;
                        raw_sum = raw_sum + v;
                    end
                end
            end
            KIND_START: begin
                running = 1'b1;
                seed_next = 1'b1;
            end
            KIND_CLEAR: begin
                latest_raw = '0;
                lowest_raw = '0;
                highest_raw = '0;
                taken = '0;
                raw_sum = '0;
                running = 1'b0;
                seed_next = 1'b0;
            end
            default: ;
        endcase
        r.current_cv = raw_to_cv(latest_raw);
        r.min_cv     = raw_to_cv(lowest_raw);
        r.max_cv     = raw_to_cv(highest_raw);
        r.avg_cv     = mean_cv();
        r.count      = taken;
        r.running    = running;
        expected_readings.push_back(r);
    endtask

    // Driver: offers queued items, idling at random
    always @(posedge i_clk) begin : drive_items
        adc_item_t it;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                predict_reading(s_axis_tuser, s_axis_tdata[SAMPLE_W-1:0]);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (items_to_send.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    it = items_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= IN_DATA_W'(it.value);
                    s_axis_tuser  <= it.kind;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here once armed
    always @(posedge i_clk) begin
        rx_hold <= hold_armed && hold_count < HOLD_CYCLES;
        if (hold_armed && hold_count < HOLD_CYCLES)
            hold_count <= hold_count + 1;
    end

    // Monitor: checks each accepted reading, stalls at random
    always @(posedge i_clk) begin : check_readings
        reading_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_readings.size() == 0) begin
                    report_mismatch("unexpected reading, queue depth", 1, 0);
                end else begin
                    want = expected_readings.pop_front();
                    if (m_axis_tdata[9:0] !== want.current_cv)
                        report_mismatch("current_centivolts", m_axis_tdata[9:0], want.current_cv);
                    if (m_axis_tdata[19:10] !== want.min_cv)
                        report_mismatch("min_centivolts", m_axis_tdata[19:10], want.min_cv);
                    if (m_axis_tdata[29:20] !== want.max_cv)
                        report_mismatch("max_centivolts", m_axis_tdata[29:20], want.max_cv);
                    if (m_axis_tdata[39:30] !== want.avg_cv)
                        report_mismatch("avg_centivolts", m_axis_tdata[39:30], want.avg_cv);
                    if (m_axis_tdata[71:40] !== want.count)
                        report_mismatch("samples_taken", m_axis_tdata[71:40], want.count);
                    if (m_axis_tdata[72] !== want.running)
                        report_mismatch("is_running", m_axis_tdata[72], want.running);
                end
            end
            m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Configuration access, only while the block is idle
    task automatic write_full_scale(logic [FS_BITS-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_FULL_SCALE;
        pwdata  <= APB_DATA_BITS'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        fs_model = value;
    endtask

    task automatic check_full_scale();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_FULL_SCALE;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== APB_DATA_BITS'(fs_model))
            report_mismatch("full scale read-back", prdata, fs_model);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_W'($urandom_range(1023));
        endcase
    endfunction

    task automatic queue_item(logic [KIND_BITS-1:0] kind, logic [SAMPLE_W-1:0] v);
        adc_item_t it;
        it.kind = kind;
        it.value = v;
        items_to_send.push_back(it);
    endtask

    // Mostly start-then-samples runs, with clears, restarts and unused kinds
    task automatic queue_random_runs(int n);
        int added;
        int len;
        int r;
        added = 0;
        while (added < n) begin
            if ($urandom_range(99) < 12) begin
                queue_item(KIND_CLEAR, pick_sample());
                added++;
                if ($urandom_range(1)) begin
                    // sample while stopped
                    queue_item(KIND_SAMPLE, pick_sample());
                    added++;
                end
            end
            queue_item(KIND_START, SAMPLE_W'($urandom));
            added++;
            len = $urandom_range(1, 40);
            for (int k = 0; k < len; k++) begin
                r = $urandom_range(99);
                if (r < 3)
                    queue_item(KIND_UNUSED, SAMPLE_W'($urandom));
                else if (r < 6)
                    queue_item(KIND_START, SAMPLE_W'($urandom));
                else
                    queue_item(KIND_SAMPLE, pick_sample());
            end
            added += len;
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (items_to_send.size() != 0 || s_axis_tvalid || expected_readings.size() != 0);
        repeat (DRAIN_SLACK) @(negedge i_clk);
    endtask

    task automatic run_phase(logic [FS_BITS-1:0] fs, int tx_pct, int rx_pct, bit hold);
        write_full_scale(fs);
        check_full_scale();
        @(negedge i_clk);
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        queue_random_runs(PHASE_ITEMS);
        if (hold)
            hold_armed = 1'b1;
        wait_drained();
    endtask

    // Main sequence
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        check_full_scale();

        // Directed: stopped samples, unused kind, extremes, restarts, clears
        @(negedge i_clk);
        queue_item(KIND_SAMPLE, 10'd700);
        queue_item(KIND_UNUSED, 10'h3FF);
        queue_item(KIND_START, 10'd0);
        queue_item(KIND_SAMPLE, 10'd0);
        queue_item(KIND_SAMPLE, 10'h3FF);
        queue_item(KIND_SAMPLE, 10'd512);
        queue_item(KIND_SAMPLE, 10'h155);
        queue_item(KIND_SAMPLE, 10'h2AA);
        queue_item(KIND_START, 10'h3FF);     // min/max keep old values until next sample
        queue_item(KIND_SAMPLE, 10'd300);
        queue_item(KIND_SAMPLE, 10'h3FF);
        queue_item(KIND_START, 10'd0);
        queue_item(KIND_START, 10'd0);
        queue_item(KIND_SAMPLE, 10'd1);
        queue_item(KIND_UNUSED, 10'd5);
        queue_item(KIND_CLEAR, 10'h2AA);
        queue_item(KIND_SAMPLE, 10'd900);
        queue_item(KIND_CLEAR, 10'd0);
        queue_item(KIND_START, 10'd0);
        queue_item(KIND_SAMPLE, 10'h3FF);
        queue_item(KIND_SAMPLE, 10'h3FF);
        queue_item(KIND_SAMPLE, 10'd0);
        wait_drained();

        run_phase(10'd1000, 0, 0, 1'b0);
        run_phase(10'd1, 60, 0, 1'b0);
        run_phase(10'd1023, 0, 60, 1'b0);
        run_phase(10'd0, 35, 35, 1'b0);
        // sender keeps offering while the receiver holds off
        run_phase(FS_BITS'($urandom_range(1, 1000)), 0, 20, 1'b1);

        if (error_count == 0 && expected_readings.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
design/avs_pkg.sv
design/avs_front.sv
design/avs_back.sv
design/adc_voltage_statistics.sv
design/avs_checker.sv
test/tb_adc_voltage_statistics.sv
